[design/brf_pkg.sv]
// Shared constants and types for the byte ring FIFO.
package brf_pkg;

	localparam int SLOTS_DEF     = 256;
	localparam int MAX_BURST_DEF = 64;

	localparam int DATA_W   = 8;
	localparam int LEN_W    = 7;
	localparam int CAP_W    = 8;
	localparam int ADDR_W   = 8;
	localparam int RING_W   = ADDR_W + 1;
	localparam int RING_MAX = 1 << ADDR_W;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;

	typedef enum logic [1:0] {
		CMD_FAIL,
		CMD_WRITE,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [ADDR_W-1:0]  addr;
		logic [DATA_W-1:0]  data;
		logic [LEN_W-1:0]   len;
	} cmd_t;

endpackage

[design/brf_if.sv]
// Handshake channels of the byte ring FIFO: request, response and capacity write.
interface brf_req_if;
	import brf_pkg::*;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [DATA_W-1:0]  data;
	logic               first;
	logic [LEN_W-1:0]   length;
	modport source (output valid, mode, data, first, length, input ready);
	modport sink (input valid, mode, data, first, length, output ready);
endinterface

interface brf_rsp_if;
	import brf_pkg::*;
	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  read_data;
	logic               status;
	logic               last;
	modport source (output valid, read_data, status, last, input ready);
	modport sink (input valid, read_data, status, last, output ready);
endinterface

interface brf_cfg_if;
	import brf_pkg::*;
	logic               valid;
	logic               ready;
	logic [CAP_W-1:0]   capacity;
	modport source (output valid, capacity, input ready);
	modport sink (input valid, capacity, output ready);
endinterface

[design/brf_front.sv]
// Front end: takes request words, keeps the ring bookkeeping and classifies each word.
module brf_front #(
	parameter int SLOTS     = brf_pkg::SLOTS_DEF,
	parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	brf_req_if.sink                     req,
	brf_cfg_if.sink                     cfg,
	input  logic                        q_full,
	output logic                        push,
	output brf_pkg::cmd_t               push_cmd,
	output logic [brf_pkg::RING_W-1:0]  ring_size
);
	import brf_pkg::*;

	localparam int EFF = (SLOTS > RING_MAX) ? RING_MAX : SLOTS;
	localparam logic [RING_W-1:0] EFF_R = RING_W'(EFF);
	localparam logic [LEN_W-1:0]  MAX_L = LEN_W'(MAX_BURST);

	logic [CAP_W-1:0]  cap_q;
	logic [ADDR_W-1:0] head_q, tail_q;
	logic [RING_W-1:0] used_q;
	logic [LEN_W-1:0]  bl_q;
	logic              brej_q;

	logic [RING_W-1:0] ring_raw, free_b, head_inc, tail_sum;
	logic [ADDR_W-1:0] head_nx, tail_nx;
	logic [LEN_W-1:0]  blen, bl_cur, bl_dec;
	logic              newb, rej_new, rej, rd_fail, acc;

	assign ring_raw  = {1'b0, cap_q} + RING_W'(1);
	assign ring_size = (ring_raw > EFF_R) ? EFF_R : ring_raw;
	assign free_b    = ring_size - RING_W'(1) - used_q;

	assign req.ready = !q_full;
	assign cfg.ready = 1'b1;
	assign acc       = req.valid && req.ready;

	always_comb begin
		// a byte with no open burst counts as a burst of one
		newb    = req.first || (bl_q == '0);
		blen    = req.first ? req.length : LEN_W'(1);
		rej_new = (blen == '0) || (blen > MAX_L) || ({2'b00, blen} > free_b);
		bl_cur  = newb ? blen : bl_q;
		bl_dec  = (bl_cur != '0) ? bl_cur - LEN_W'(1) : bl_cur;
		rej     = newb ? rej_new : brej_q;

		head_inc = {1'b0, head_q} + RING_W'(1);
		head_nx  = (head_inc == ring_size) ? '0 : head_inc[ADDR_W-1:0];

		rd_fail  = (req.length == '0) || (req.length > MAX_L) ||
			({2'b00, req.length} > used_q);
		tail_sum = {1'b0, tail_q} + {2'b00, req.length};
		tail_nx  = (tail_sum >= ring_size) ? ADDR_W'(tail_sum - ring_size)
			: tail_sum[ADDR_W-1:0];

		push          = acc;
		push_cmd.data = req.data;
		push_cmd.len  = req.length;
		if (req.mode) begin
			push_cmd.kind = rd_fail ? CMD_FAIL : CMD_READ;
			push_cmd.addr = tail_q;
		end else begin
			push_cmd.kind = rej ? CMD_FAIL : CMD_WRITE;
			push_cmd.addr = head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
			bl_q   <= '0;
			brej_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			cap_q  <= cfg.capacity;
			head_q <= '0;
			tail_q <= '0;
			used_q <= '0;
			bl_q   <= '0;
			brej_q <= 1'b0;
		end else if (acc) begin
			if (req.mode) begin
				if (!rd_fail) begin
					tail_q <= tail_nx;
					used_q <= used_q - {2'b00, req.length};
				end
			end else begin
				bl_q   <= bl_dec;
				brej_q <= rej && (bl_dec != '0);
				if (!rej) begin
					head_q <= head_nx;
					used_q <= used_q + RING_W'(1);
				end
			end
		end
	end

endmodule

[design/brf_queue.sv]
// Two-entry command queue between front and back end.
module brf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  brf_pkg::cmd_t  push_cmd,
	output logic           full,
	output logic           valid,
	output brf_pkg::cmd_t  cmd,
	input  logic           pop
);
	import brf_pkg::*;

	cmd_t       ents_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign cmd   = ents_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			ents_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/brf_back.sv]
// Back end: owns the byte store, runs queued commands and drives the response register.
module brf_back #(
	parameter int SLOTS = brf_pkg::SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  brf_pkg::cmd_t               q_cmd,
	output logic                        q_pop,
	input  logic [brf_pkg::RING_W-1:0]  ring_size,
	brf_rsp_if.source                   rsp
);
	import brf_pkg::*;

	localparam int EFF = (SLOTS > RING_MAX) ? RING_MAX : SLOTS;
	localparam int PW  = $clog2(EFF);

	logic [DATA_W-1:0] mem [EFF];

	logic              act_q;
	cmd_t              cmd_q;
	logic              out_valid_q, status_q, last_q, isrd_q;
	logic [DATA_W-1:0] rd_q;

	logic              adv, fire, fin, beat_last;
	logic [RING_W-1:0] a_inc;
	logic [ADDR_W-1:0] a_nx;
	logic [PW-1:0]     idx;

	assign adv       = !out_valid_q || rsp.ready;
	assign fire      = act_q && adv;
	assign beat_last = (cmd_q.kind != CMD_READ) || (cmd_q.len == LEN_W'(1));
	assign fin       = fire && beat_last;
	// next command loads in the cycle the current one issues its final beat
	assign q_pop     = q_valid && (!act_q || fin);

	assign a_inc = {1'b0, cmd_q.addr} + RING_W'(1);
	assign a_nx  = (a_inc == ring_size) ? '0 : a_inc[ADDR_W-1:0];
	assign idx   = cmd_q.addr[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			act_q <= 1'b0;
		else if (q_pop)
			act_q <= 1'b1;
		else if (fin)
			act_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end else if (fire) begin
			cmd_q.addr <= a_nx;
			cmd_q.len  <= cmd_q.len - LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (cmd_q.kind == CMD_WRITE)
				mem[idx] <= cmd_q.data;
			rd_q <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= act_q;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= (cmd_q.kind == CMD_FAIL);
			last_q   <= beat_last;
			isrd_q   <= (cmd_q.kind == CMD_READ);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = isrd_q ? rd_q : '0;
	assign rsp.status    = status_q;
	assign rsp.last      = last_q;

endmodule

[design/byte_ring_fifo_bulk.sv]
// Byte ring FIFO with bulk write admission and multi-byte reads (top level).
//
// req carries one word per item: mode 0 writes one byte (first marks a
// burst opener whose length is checked against free space as a whole),
// mode 1 asks for length bytes. rsp returns one word per result: a write
// or a failed read gives a single word with last set; a good read gives
// length words, the final one with last set. cfg writes the capacity
// (ring of capacity+1 slots) and empties the FIFO; it is always ready.
// The user must write it only while nothing is in flight; the block does
// not enforce this. An accepted request passes the command queue, the back
// end command register, then the store read / response register before its
// first response word shows. Throughput: one request per cycle for writes
// while the queue is not full; a read holds the back end until all its
// bytes are returned, one word per cycle, set by the single store read
// port. Requests keep entering the two-entry command queue meanwhile. When
// rsp stalls the response register holds, the back end stops and req.ready
// drops once the queue fills. Reset empties the FIFO and sets capacity to
// 255; stored bytes are undefined until written.
module byte_ring_fifo_bulk #(
	parameter int SLOTS     = brf_pkg::SLOTS_DEF,
	parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	brf_req_if.sink    req,
	brf_rsp_if.source  rsp,
	brf_cfg_if.sink    cfg
);
	import brf_pkg::*;

	logic              push, q_full, q_valid, q_pop;
	cmd_t              push_cmd, q_cmd;
	logic [RING_W-1:0] ring_size;

	brf_front #(
		.SLOTS     (SLOTS),
		.MAX_BURST (MAX_BURST)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd),
		.ring_size (ring_size)
	);

	brf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.valid    (q_valid),
		.cmd      (q_cmd),
		.pop      (q_pop)
	);

	brf_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.ring_size (ring_size),
		.rsp       (rsp)
	);

endmodule

[design/brf_checker.sv]
// Port-level checks for the byte ring FIFO, bound to the top level.
module brf_checker (
	input  logic       clk,
	input  logic       arst_n,
	brf_rsp_if.source  rsp,
	brf_cfg_if.sink    cfg
);

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.read_data) &&
			$stable(rsp.status) && $stable(rsp.last))
		else $error("response word changed while stalled");

	// failures are single words with no data
	a_fail_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> rsp.last && (rsp.read_data == '0))
		else $error("failure word carries data or is not last");

	// only successful reads span several words
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.last |-> !rsp.status)
		else $error("non-final word reports failure");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |-> cfg.ready)
		else $error("capacity write not taken");

endmodule

bind byte_ring_fifo_bulk brf_checker u_brf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.rsp    (rsp),
	.cfg    (cfg)
);

[test/tb_byte_ring_fifo_bulk.sv]
// Self-checking testbench for the byte ring FIFO: directed corner items, then random phases.
module tb_byte_ring_fifo_bulk;
	timeunit 1ns;
	timeprecision 1ps;

	import brf_pkg::*;

	localparam bit MODE_WRITE = 1'b0;
	localparam bit MODE_READ  = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              status;
		logic              last;
	} rsp_word_t;

	// Mirror of the ring: predicts the response words of every accepted request.
	class fifo_scoreboard;
		logic [DATA_W-1:0] ring [RING_MAX];
		int unsigned       cap;
		int unsigned       head;
		int unsigned       tail;
		int unsigned       burst_left;
		bit                burst_reject;
		rsp_word_t         due_q[$];
		int                errors;

		function new();
			errors = 0;
			set_capacity(int'(CAP_RESET));
		endfunction

		function void set_capacity(int unsigned c);
			cap          = c;
			head         = 0;
			tail         = 0;
			burst_left   = 0;
			burst_reject = 1'b0;
		endfunction

		function int unsigned slots();
			return cap + 1;
		endfunction

		function int unsigned fill();
			return (head + slots() - tail) % slots();
		endfunction

		function int unsigned space();
			return slots() - 1 - fill();
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void queue_word(logic [DATA_W-1:0] d, logic st, logic lst);
			rsp_word_t w;
			w.read_data = d;
			w.status    = st;
			w.last      = lst;
			due_q.push_back(w);
		endfunction

		function void note_request(bit mode, logic [DATA_W-1:0] data, bit first,
				logic [LEN_W-1:0] length);
			int unsigned len;
			if (mode == MODE_WRITE) begin
				// a stray byte with no open burst counts as a burst of one
				if (first || burst_left == 0) begin
					len          = first ? int'(length) : 1;
					burst_reject = (len == 0) || (len > MAX_BURST_DEF) || (len > space());
					burst_left   = len;
				end
				if (burst_left > 0)
					burst_left--;
				if (burst_reject) begin
					if (burst_left == 0)
						burst_reject = 1'b0;
					queue_word('0, 1'b1, 1'b1);
				end else begin
					ring[head] = data;
					head       = (head + 1) % slots();
					queue_word('0, 1'b0, 1'b1);
				end
			end else if (length == 0 || length > MAX_BURST_DEF || length > fill()) begin
				queue_word('0, 1'b1, 1'b1);
			end else begin
				for (int k = 0; k < int'(length); k++) begin
					queue_word(ring[tail], 1'b0, k + 1 == int'(length));
					tail = (tail + 1) % slots();
				end
			end
		endfunction

		function void check_word(rsp_word_t got);
			rsp_word_t want;
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t: response word with nothing expected: read_data %02h status %0b last %0b",
					$time, got.read_data, got.status, got.last);
				return;
			end
			want = due_q.pop_front();
			if (got.read_data !== want.read_data) begin
				errors++;
				$display("%0t: read_data expected %02h actual %02h",
					$time, want.read_data, got.read_data);
			end
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   rsp_stall_pct;

	brf_req_if req();
	brf_rsp_if rsp();
	brf_cfg_if cfg();

	fifo_scoreboard sb = new();

	byte_ring_fifo_bulk dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
	end

	// Sample at the edge, check a moment later so request bookkeeping of the same edge is done.
	initial begin : rsp_monitor
		rsp_word_t seen;
		bit        took;
		forever begin
			@(posedge clk);
			took = (rsp.valid === 1'b1) && (rsp.ready === 1'b1) && (arst_n === 1'b1);
			seen = {rsp.read_data, rsp.status, rsp.last};
			#1;
			if (took)
				sb.check_word(seen);
		end
	end

	task automatic send_word(bit mode, logic [DATA_W-1:0] data, bit first,
			logic [LEN_W-1:0] length);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid  <= 1'b1;
		req.mode   <= mode;
		req.data   <= data;
		req.first  <= first;
		req.length <= length;
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.note_request(mode, data, first, length);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] c);
		drain();
		cfg.valid    <= 1'b1;
		cfg.capacity <= c;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		sb.set_capacity(int'(c));
		cfg.valid <= 1'b0;
	endtask

	task automatic random_phase(int unsigned quota);
		int unsigned n;
		int unsigned pick;
		int unsigned len;
		int unsigned cnt;
		int unsigned lim;
		n = 0;
		while (n < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// burst of random bytes, mostly short and mostly fitting the free space
				len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : $urandom_range(1, 64);
				if (sb.space() > 0 && $urandom_range(0, 3) != 0 && len > sb.space())
					len = $urandom_range(1, sb.space() < 64 ? sb.space() : 64);
				cnt = ($urandom_range(0, 99) < 15) ? $urandom_range(1, len) : len;
				// a burst cut short by the quota is abandoned by the next opener
				if (cnt > quota - n)
					cnt = quota - n;
				send_word(MODE_WRITE, DATA_W'($urandom), 1'b1, LEN_W'(len));
				n++;
				for (int k = 1; k < int'(cnt); k++) begin
					if ($urandom_range(0, 9) == 0 && sb.fill() > 0) begin
						send_word(MODE_READ, DATA_W'($urandom), 1'($urandom),
							LEN_W'($urandom_range(1, sb.fill())));
						n++;
					end
					send_word(MODE_WRITE, DATA_W'($urandom), 1'b0, LEN_W'($urandom));
					n++;
				end
			end else if (pick < 85) begin
				lim = sb.fill() < 64 ? sb.fill() : 64;
				if (lim > 0 && $urandom_range(0, 4) != 0)
					send_word(MODE_READ, DATA_W'($urandom), 1'($urandom),
						LEN_W'($urandom_range(1, lim)));
				else
					send_word(MODE_READ, DATA_W'($urandom), 1'($urandom),
						LEN_W'($urandom_range(0, 127)));
				n++;
			end else begin
				send_word(1'($urandom), DATA_W'($urandom), 1'($urandom),
					LEN_W'($urandom_range(0, 127)));
				n++;
			end
		end
	endtask

	initial begin : stimulus
		clk           = 1'b0;
		arst_n        = 1'b0;
		src_idle_pct  = 0;
		rsp_stall_pct = 0;
		req.valid     = 1'b0;
		req.mode      = MODE_WRITE;
		req.data      = '0;
		req.first     = 1'b0;
		req.length    = '0;
		rsp.ready     = 1'b0;
		cfg.valid     = 1'b0;
		cfg.capacity  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty read, extremes, read inside a burst, bad burst lengths
		send_word(MODE_READ, 8'h00, 1'b0, 7'd1);
		send_word(MODE_WRITE, 8'h00, 1'b1, 7'd3);
		send_word(MODE_WRITE, 8'hFF, 1'b0, 7'd0);
		send_word(MODE_WRITE, 8'hA5, 1'b0, 7'd0);
		send_word(MODE_WRITE, 8'h5A, 1'b1, 7'd2);
		send_word(MODE_READ, 8'hFF, 1'b1, 7'd4);
		send_word(MODE_WRITE, 8'h3C, 1'b0, 7'd0);
		send_word(MODE_WRITE, 8'h11, 1'b1, 7'd0);
		send_word(MODE_WRITE, 8'h81, 1'b0, 7'd0);
		send_word(MODE_WRITE, 8'h22, 1'b1, 7'd127);
		send_word(MODE_WRITE, 8'h33, 1'b0, 7'd127);
		send_word(MODE_WRITE, 8'h7E, 1'b1, 7'd1);
		send_word(MODE_READ, 8'h00, 1'b0, 7'd0);
		send_word(MODE_READ, 8'h00, 1'b0, 7'd127);
		send_word(MODE_READ, 8'h00, 1'b0, 7'd64);
		send_word(MODE_READ, 8'h00, 1'b0, 7'd3);

		// no usable space at all
		write_capacity(8'd0);
		send_word(MODE_WRITE, 8'h44, 1'b1, 7'd1);
		send_word(MODE_READ, 8'h00, 1'b0, 7'd1);

		// one usable byte
		write_capacity(8'd1);
		send_word(MODE_WRITE, 8'h55, 1'b1, 7'd2);
		send_word(MODE_WRITE, 8'h66, 1'b0, 7'd0);
		send_word(MODE_WRITE, 8'h77, 1'b1, 7'd1);
		send_word(MODE_WRITE, 8'h88, 1'b0, 7'd0);
		send_word(MODE_READ, 8'h00, 1'b0, 7'd1);

		write_capacity(8'd255);
		random_phase(17);

		write_capacity(8'd23);
		src_idle_pct = 59;
		random_phase(17);

		write_capacity(8'd100);
		src_idle_pct  = 0;
		rsp_stall_pct = 59;
		random_phase(17);

		write_capacity(8'd2);
		src_idle_pct  = 10;
		rsp_stall_pct = 10;
		random_phase(17);

		write_capacity(CAP_W'($urandom_range(1, 255)));
		random_phase(17);

		req.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
